@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is active
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define AST_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/irps_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irps_pkg
// Types and constants of the IR timing to pulse-symbol packer.
// ---------------------------------------------------------------------------
package irps_pkg;

  // Longest half of a symbol word in ticks
  localparam logic [14:0] PHASE_MAX = 15'h7FFF;

  // Result queue depth and its pointer / count widths
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QCW    = 3;

  // One result item
  typedef struct packed {
    logic        first_level;
    logic [14:0] first_ticks;
    logic        second_level;
    logic [14:0] second_ticks;
    logic        word_valid;
    logic        run_end;
  } sym_t;

  // Results produced by one item, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    sym_t       r0;
    sym_t       r1;
  } push_t;

endpackage

@@ rtl/irps_pack.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irps_pack
// Splits one duration into phases, pairs them with a held phase into
// symbol words and keeps the per-run state.
// ---------------------------------------------------------------------------
module irps_pack #(
  parameter int MAX_DURATIONS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [15:0]   duration,
  input  logic          final_item,
  output irps_pkg::push_t push
);
  import irps_pkg::*;

  localparam int CAP = 2 * MAX_DURATIONS;
  localparam int TW  = $clog2(CAP + 1);
  localparam logic [TW-1:0] CAP_V = TW'(CAP);

  // run state
  logic          parity_r, parity_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic          held_level_r, held_level_nxt;
  logic [14:0]   held_ticks_r, held_ticks_nxt;
  logic [TW-1:0] total_r, total_nxt;

  logic          lvl;
  logic [1:0]    nph;
  logic [1:0]    k;
  logic [TW-1:0] room;
  logic [2:0]    m;
  logic [14:0]   p0, p1;
  logic [15:0]   rest;
  logic [3:0]    ph_lvl;
  logic [14:0]   ph_tk [4];
  logic [1:0]    nwords;

  always_comb begin
    lvl  = ~parity_r;
    rest = duration - {1'b0, PHASE_MAX};

    // phase lengths: a full phase, then the rest
    p0 = (duration > {1'b0, PHASE_MAX}) ? PHASE_MAX : duration[14:0];
    p1 = (rest > {1'b0, PHASE_MAX}) ? PHASE_MAX : rest[14:0];
    if (duration == 16'd0) begin
      nph = 2'd0;
    end else if (duration <= {1'b0, PHASE_MAX}) begin
      nph = 2'd1;
    end else if (duration == 16'hFFFF) begin
      nph = 2'd3;
    end else begin
      nph = 2'd2;
    end

    // clip to the run's phase capacity
    room = CAP_V - total_r;
    k    = (room >= TW'(nph)) ? nph : room[1:0];
    m    = {2'b00, held_valid_r} + {1'b0, k};

    // phase list: held phase first, then the new ones
    if (held_valid_r) begin
      ph_lvl   = {lvl, lvl, lvl, held_level_r};
      ph_tk[0] = held_ticks_r;
      ph_tk[1] = p0;
      ph_tk[2] = p1;
      ph_tk[3] = 15'd1;
    end else begin
      ph_lvl   = {lvl, lvl, lvl, lvl};
      ph_tk[0] = p0;
      ph_tk[1] = p1;
      ph_tk[2] = 15'd1;
      ph_tk[3] = 15'd0;
    end

    // words: full pairs, plus a padded word or an end marker on the last item
    nwords = m[2:1];
    if (final_item && m[0]) begin
      nwords = nwords + 2'd1;
    end
    if (final_item && nwords == 2'd0) begin
      nwords = 2'd1;
    end

    push.cnt                 = fire ? nwords : 2'd0;
    push.r0.word_valid       = (m != 3'd0);
    push.r0.first_level      = (m != 3'd0) ? ph_lvl[0] : 1'b0;
    push.r0.first_ticks      = (m != 3'd0) ? ph_tk[0] : 15'd0;
    push.r0.second_level     = (m >= 3'd2) ? ph_lvl[1] : 1'b0;
    push.r0.second_ticks     = (m >= 3'd2) ? ph_tk[1] : 15'd0;
    push.r0.run_end          = final_item && (nwords == 2'd1);
    push.r1.word_valid       = 1'b1;
    push.r1.first_level      = ph_lvl[2];
    push.r1.first_ticks      = ph_tk[2];
    push.r1.second_level     = (m == 3'd4) ? ph_lvl[3] : 1'b0;
    push.r1.second_ticks     = (m == 3'd4) ? ph_tk[3] : 15'd0;
    push.r1.run_end          = final_item;

    // next state; the last item returns everything to reset values
    parity_nxt     = ~parity_r;
    held_valid_nxt = m[0];
    held_level_nxt = (m == 3'd1) ? ph_lvl[0] : ph_lvl[2];
    held_ticks_nxt = (m == 3'd1) ? ph_tk[0] : ph_tk[2];
    total_nxt      = total_r + TW'(k);
    if (final_item) begin
      parity_nxt     = 1'b0;
      held_valid_nxt = 1'b0;
      held_level_nxt = 1'b0;
      held_ticks_nxt = 15'd0;
      total_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r     <= 1'b0;
      held_valid_r <= 1'b0;
      held_level_r <= 1'b0;
      held_ticks_r <= 15'd0;
      total_r      <= '0;
    end else if (fire) begin
      parity_r     <= parity_nxt;
      held_valid_r <= held_valid_nxt;
      held_level_r <= held_level_nxt;
      held_ticks_r <= held_ticks_nxt;
      total_r      <= total_nxt;
    end
  end

endmodule

@@ rtl/irps_fifo.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irps_fifo
// Result queue: takes up to two words per cycle, hands out one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module irps_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  irps_pkg::push_t push,
  output logic            room2,
  output logic            out_valid,
  input  logic            out_ready,
  output irps_pkg::sym_t  out_sym
);
  import irps_pkg::*;

  sym_t           mem [QDEPTH];
  logic [QPW-1:0] wptr_r, wptr_nxt;
  logic [QPW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign out_sym   = mem[rptr_r];
  assign room2     = (cnt_r <= QCW'(QDEPTH - 2));
  assign pop       = out_valid && out_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wptr_nxt = wptr_r + QPW'(push.cnt);
    rptr_nxt = rptr_r + QPW'(pop);
    cnt_nxt  = cnt_r + QCW'(push.cnt) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wptr_r + QPW'(1)] <= push.r1;
    end
  end

endmodule

@@ rtl/ir_timing_to_pulse_symbols.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ir_timing_to_pulse_symbols
// Packs IR mark/space durations into two-half pulse-symbol words.
// ---------------------------------------------------------------------------
// Channel | Ports                                   | Transfer
// in      | in_duration, in_final_item              | in_valid & in_ready
// out     | out_first_*, out_second_*, out_word_valid, out_run_end
//                                                   | out_valid & out_ready
//
// An item waits in the input register until the queue has room for two words,
// then is packed in one pass into zero to two words pushed to a 4-entry result
// queue. The queue drains one word per cycle while out_ready is high, so the
// output port sets the sustained rate.
// Input keeps flowing while results wait, until the queue has < 2 free slots.
// Synchronous reset clears the run state, the input register and the queue.
// ---------------------------------------------------------------------------
module ir_timing_to_pulse_symbols #(
  parameter int MAX_DURATIONS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_duration,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_first_level,
  output logic [14:0] out_first_ticks,
  output logic        out_second_level,
  output logic [14:0] out_second_ticks,
  output logic        out_word_valid,
  output logic        out_run_end
);
  import irps_pkg::*;

  logic        in_valid_r;
  logic [15:0] dur_r;
  logic        final_r;
  logic        fire;
  logic        room2;
  push_t       push;
  sym_t        out_sym;

  assign fire     = in_valid_r && room2;
  assign in_ready = !in_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dur_r   <= in_duration;
      final_r <= in_final_item;
    end
  end

  irps_pack #(
    .MAX_DURATIONS(MAX_DURATIONS)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .duration   (dur_r),
    .final_item (final_r),
    .push       (push)
  );

  irps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sym   (out_sym)
  );

  assign out_first_level  = out_sym.first_level;
  assign out_first_ticks  = out_sym.first_ticks;
  assign out_second_level = out_sym.second_level;
  assign out_second_ticks = out_sym.second_ticks;
  assign out_word_valid   = out_sym.word_valid;
  assign out_run_end      = out_sym.run_end;

endmodule

@@ rtl/irps_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irps_checker
// Port-level checks of the pulse-symbol packer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module irps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] out_first_ticks,
  input logic        out_second_level,
  input logic [14:0] out_second_ticks,
  input logic        out_word_valid,
  input logic        out_run_end
);

  // a stalled result stays offered
  `AST_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out dropped")

  // an end marker carries no word and closes the run
  `AST_CLK(a_marker, clk, rst_n, out_valid && !out_word_valid |-> out_run_end && out_first_ticks == 15'd0 && out_second_ticks == 15'd0, "bad end marker")

  // a word never has an empty first half
  `AST_CLK(a_first_nz, clk, rst_n, out_valid && out_word_valid |-> out_first_ticks != 15'd0, "empty first half")

  // a padded second half has level zero
  `AST_CLK(a_pad_lvl, clk, rst_n, out_valid && out_second_ticks == 15'd0 |-> !out_second_level, "padded half with level")

  // queue is empty right after reset
  `AST_CLK_NR(a_rst_empty, clk, !rst_n |=> !out_valid, "output after reset")

endmodule

bind ir_timing_to_pulse_symbols irps_checker u_irps_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the IR timing to pulse-symbol packer. A short table
// of hand-picked durations comes first, then random runs of marks and spaces.
// A bit-exact packer model (or a row's typed words) gives the symbol words due
// for every accepted duration; every word transfer is compared field by field.
// ---------------------------------------------------------------------------
module tb;
  import irps_pkg::*;

  localparam int MAX_DURATIONS  = 256;
  localparam int PHASE_CAP      = 2 * MAX_DURATIONS;
  localparam int TOTAL_ITEMS    = 1300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  // One duration to send, with the words typed in when they are obvious
  typedef struct {
    logic [15:0] dur;
    logic        fin;
    bit          typed;
    int          n;
    sym_t        w0;
    sym_t        w1;
  } dur_item_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [15:0] in_duration      = '0;
  logic        in_final_item    = 1'b0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic        out_first_level;
  logic [14:0] out_first_ticks;
  logic        out_second_level;
  logic [14:0] out_second_ticks;
  logic        out_word_valid;
  logic        out_run_end;

  // Packer model state
  logic                               run_parity;
  logic                               held_ok;
  logic                               held_lvl;
  logic [14:0]                        held_len;
  logic [$clog2(PHASE_CAP + 1) - 1:0] phase_cnt;
  sym_t                               packed_words [2];
  int                                 packed_n;

  dur_item_t durs_in_flight [$];
  dur_item_t dir_tab        [$];
  sym_t      words_due      [$];

  int snd_gap_pct    = 0;
  int rcv_gap_pct    = 0;
  int durations_sent = 0;
  int runs_sent      = 0;
  int words_seen     = 0;
  int capped_items   = 0;
  int mismatch_cnt   = 0;
  int stall_cycles   = 0;

  ir_timing_to_pulse_symbols #(
    .MAX_DURATIONS(MAX_DURATIONS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_duration     (in_duration),
    .in_final_item   (in_final_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_first_level (out_first_level),
    .out_first_ticks (out_first_ticks),
    .out_second_level(out_second_level),
    .out_second_ticks(out_second_ticks),
    .out_word_valid  (out_word_valid),
    .out_run_end     (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic sym_t sym(input logic fl, input logic [14:0] ft, input logic sl,
                               input logic [14:0] st, input logic wv, input logic re);
    sym_t w;
    w.first_level  = fl;
    w.first_ticks  = ft;
    w.second_level = sl;
    w.second_ticks = st;
    w.word_valid   = wv;
    w.run_end      = re;
    return w;
  endfunction

  task automatic clear_run();
    run_parity = 1'b0;
    held_ok    = 1'b0;
    held_lvl   = 1'b0;
    held_len   = '0;
    phase_cnt  = '0;
  endtask

  // Cut one duration into phases, pair them into words, close the run on final
  task automatic pack_symbols(input logic [15:0] dur, input logic fin);
    int unsigned left;
    logic [14:0] part;
    logic        lvl;
    left            = dur;
    lvl             = ~run_parity;
    packed_n        = 0;
    packed_words[0] = '0;
    packed_words[1] = '0;
    while (left > 0 && phase_cnt < PHASE_CAP) begin
      part      = (left > PHASE_MAX) ? PHASE_MAX : left[14:0];
      left      = left - part;
      phase_cnt = phase_cnt + 1'b1;
      if (held_ok) begin
        if (packed_n < 2) begin
          packed_words[packed_n] = sym(held_lvl, held_len, lvl, part, 1'b1, 1'b0);
          packed_n++;
        end
        held_ok = 1'b0;
      end else begin
        held_ok  = 1'b1;
        held_lvl = lvl;
        held_len = part;
      end
    end
    if (left > 0) capped_items++;
    run_parity = ~run_parity;
    if (fin) begin
      // leftover phase gets a zero second half
      if (held_ok && packed_n < 2) begin
        packed_words[packed_n] = sym(held_lvl, held_len, 1'b0, '0, 1'b1, 1'b0);
        packed_n++;
      end
      // nothing at all from the last duration: bare end marker
      if (packed_n == 0) begin
        packed_words[0] = sym(1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
        packed_n = 1;
      end
      packed_words[packed_n - 1].run_end = 1'b1;
      clear_run();
    end
  endtask

  task automatic add_row(input logic [15:0] dur, input logic fin, input bit typed,
                         input int n, input sym_t w0, input sym_t w1);
    dur_item_t r;
    r.dur   = dur;
    r.fin   = fin;
    r.typed = typed;
    r.n     = n;
    r.w0    = w0;
    r.w1    = w1;
    dir_tab.push_back(r);
  endtask

  // Hand one duration to the block; returns on the edge of its transfer
  task automatic send_duration(input dur_item_t r);
    case (durations_sent * 3 / TOTAL_ITEMS)
      0: begin
        snd_gap_pct = 31;
        rcv_gap_pct = 71;
      end
      1: begin
        snd_gap_pct = 71;
        rcv_gap_pct = 31;
      end
      default: begin
        snd_gap_pct = 0;
        rcv_gap_pct = 0;
      end
    endcase
    while ($urandom_range(0, 99) < snd_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    durs_in_flight.push_back(r);
    in_valid      <= 1'b1;
    in_duration   <= r.dur;
    in_final_item <= r.fin;
    durations_sent++;
    if (r.fin) runs_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_duration(input bit long_run);
    int sel;
    sel = $urandom_range(0, 99);
    if (long_run) begin
      if (sel < 30) return 16'hFFFF;
      if (sel < 90) return 16'($urandom_range(32768, 65534));
      return 16'($urandom_range(0, 65535));
    end
    if (sel < 10) return '0;
    if (sel < 15) return 16'hFFFF;
    if (sel < 20) return 16'($urandom_range(32767, 32768));
    if (sel < 55) return 16'($urandom_range(1, 200));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_gap_pct);
  end

  // Predict on each duration transfer, check each word transfer
  always @(posedge clk) begin : monitor
    dur_item_t r;
    sym_t      got;
    sym_t      want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        r = durs_in_flight.pop_front();
        pack_symbols(r.dur, r.fin);
        if (r.typed) begin
          packed_n        = r.n;
          packed_words[0] = r.w0;
          packed_words[1] = r.w1;
        end
        for (int k = 0; k < packed_n; k++) words_due.push_back(packed_words[k]);
      end
      if (out_valid && out_ready) begin
        got = sym(out_first_level, out_first_ticks, out_second_level, out_second_ticks,
                  out_word_valid, out_run_end);
        words_seen++;
        if (words_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: unexpected word %0d/%0d %0d/%0d valid=%0d end=%0d", $realtime,
                     got.first_level, got.first_ticks, got.second_level, got.second_ticks,
                     got.word_valid, got.run_end);
        end else begin
          want = words_due.pop_front();
          if (got.first_level  !== want.first_level  || got.first_ticks  !== want.first_ticks ||
              got.second_level !== want.second_level || got.second_ticks !== want.second_ticks ||
              got.word_valid   !== want.word_valid   || got.run_end      !== want.run_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: word mismatch exp %0d/%0d %0d/%0d v=%0d e=%0d got %0d/%0d %0d/%0d v=%0d e=%0d",
                       $realtime, want.first_level, want.first_ticks, want.second_level,
                       want.second_ticks, want.word_valid, want.run_end, got.first_level,
                       got.first_ticks, got.second_level, got.second_ticks, got.word_valid,
                       got.run_end);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d words outstanding",
               stall_cycles, words_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    dur_item_t r;
    bit        long_run;
    bit        first_run;
    int        run_len;
    clear_run();

    // Directed table: typed words where they follow straight from the rules
    add_row(16'd0,     1'b1, 1'b1, 1,
            sym(1'b0, 15'd0, 1'b0, 15'd0, 1'b0, 1'b1), '0);
    add_row(16'hFFFF,  1'b1, 1'b1, 2,
            sym(1'b1, 15'h7FFF, 1'b1, 15'h7FFF, 1'b1, 1'b0),
            sym(1'b1, 15'd1, 1'b0, 15'd0, 1'b1, 1'b1));
    add_row(16'd1,     1'b0, 1'b1, 0, '0, '0);
    add_row(16'd1,     1'b1, 1'b1, 1,
            sym(1'b1, 15'd1, 1'b0, 15'd1, 1'b1, 1'b1), '0);
    add_row(16'd32767, 1'b0, 1'b1, 0, '0, '0);
    add_row(16'd32768, 1'b1, 1'b1, 2,
            sym(1'b1, 15'h7FFF, 1'b0, 15'h7FFF, 1'b1, 1'b0),
            sym(1'b0, 15'd1, 1'b0, 15'd0, 1'b1, 1'b1));
    add_row(16'd5,     1'b0, 1'b0, 0, '0, '0);
    add_row(16'd0,     1'b0, 1'b0, 0, '0, '0);
    add_row(16'd7,     1'b1, 1'b0, 0, '0, '0);
    add_row(16'd9,     1'b0, 1'b1, 0, '0, '0);
    add_row(16'd0,     1'b1, 1'b1, 1,
            sym(1'b1, 15'd9, 1'b0, 15'd0, 1'b1, 1'b1), '0);
    add_row(16'd0,     1'b0, 1'b1, 0, '0, '0);
    add_row(16'd0,     1'b1, 1'b1, 1,
            sym(1'b0, 15'd0, 1'b0, 15'd0, 1'b0, 1'b1), '0);
    add_row(16'hFFFF,  1'b0, 1'b0, 0, '0, '0);
    add_row(16'hFFFF,  1'b0, 1'b0, 0, '0, '0);
    add_row(16'd100,   1'b1, 1'b0, 0, '0, '0);
    add_row(16'h1234,  1'b0, 1'b0, 0, '0, '0);
    add_row(16'hABCD,  1'b0, 1'b0, 0, '0, '0);
    add_row(16'd1,     1'b0, 1'b0, 0, '0, '0);
    add_row(16'd2,     1'b1, 1'b0, 0, '0, '0);

    // Reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_duration(dir_tab[i]);

    // Random runs; the first one is long and full scale to hit the phase cap
    first_run = 1'b1;
    while (durations_sent < TOTAL_ITEMS) begin
      long_run  = first_run || ($urandom_range(0, 39) == 0);
      first_run = 1'b0;
      run_len   = long_run ? $urandom_range(240, 300) : $urandom_range(1, 12);
      // last run ends at the item budget
      if (run_len > TOTAL_ITEMS - durations_sent) run_len = TOTAL_ITEMS - durations_sent;
      for (int k = 0; k < run_len; k++) begin
        r.dur   = pick_duration(long_run);
        r.fin   = (k == run_len - 1);
        r.typed = 1'b0;
        r.n     = 0;
        r.w0    = '0;
        r.w1    = '0;
        send_duration(r);
      end
    end
    in_valid <= 1'b0;

    // Drain
    while (words_due.size() != 0 || durs_in_flight.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d durations in %0d runs, %0d words checked, %0d mismatches.",
             durations_sent, runs_sent, words_seen, mismatch_cnt);
    $display("Durations cut short by the phase cap: %0d.", capped_items);
    if (mismatch_cnt == 0 && words_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
